// File: design/reader_writer_lock_manager_core_defines.svh
// Assertion macros for the reader-writer lock manager.
// Used by the top level; expects clk and arst_n in scope.
`ifndef READER_WRITER_LOCK_MANAGER_CORE_DEFINES_SVH
`define READER_WRITER_LOCK_MANAGER_CORE_DEFINES_SVH

// same-cycle implication
`define RWLM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RWLM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// delayed implication
`define RWLM_ASSERT_DLY2(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

// File: design/rwlm_pkg.sv
// Package for the reader-writer lock manager: codes, widths and defaults.
// No dependencies.
`default_nettype none

package rwlm_pkg;

	localparam int ID_W        = 6;
	localparam int ENTRY_W     = ID_W + 1;
	localparam int RC_W        = 7;
	localparam int REQUESTERS  = 64;
	localparam int DEF_QUEUE_DEPTH = 16;

	localparam logic [10:0]     REQ_LIMIT  = 11'(REQUESTERS);
	localparam logic [RC_W-1:0] READER_MAX = 7'd127;

	typedef enum logic [1:0] {
		ACT_RD_ACQ = 2'd0,
		ACT_RD_REL = 2'd1,
		ACT_WR_ACQ = 2'd2,
		ACT_WR_REL = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_RELEASED = 3'd2,
		ST_WOKEN    = 3'd3,
		ST_REL_ERR  = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

endpackage

`default_nettype wire

// File: design/rwlm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on rwlm_pkg for default sizes.
`default_nettype none

module rwlm_ram
	import rwlm_pkg::*;
#(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = DEF_QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/reader_writer_lock_manager_core.sv
// Reader-writer lock manager with a FIFO wait queue held in RAM.
// Depends on rwlm_pkg, rwlm_ram and reader_writer_lock_manager_core_defines.svh.
//
// channel   direction  handshake          word
// request   in         start && !busy     action, requester_id
// result    out        strobe, one cycle  target_id, write_mode, status, last
//
// A request passes through accept and then execute, and gives its first result
// the cycle after execution; each woken waiter adds one more result word, as the wait
// queue RAM delivers one entry a cycle. busy is high from accept to the last
// result decision. Reset clears the lock state and the queue pointers; the
// queue RAM needs no clearing. Results cannot be stalled.
`default_nettype none

`include "reader_writer_lock_manager_core_defines.svh"

module reader_writer_lock_manager_core
	import rwlm_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [1:0]       action,
	input  wire logic [ID_W-1:0]  requester_id,
	output logic                  strobe,
	output logic      [ID_W-1:0]  target_id,
	output logic                  write_mode,
	output logic      [2:0]       status,
	output logic                  last
);

	localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = HW + 1;
	localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(QUEUE_DEPTH);
	localparam logic [SW-1:0] DEPTH_S   = SW'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_CHK  = 3'b100
	} state_t;

	state_t state_q, state_d;

	action_t         act_q;
	logic [ID_W-1:0] id_q;

	logic [RC_W-1:0] rc_q, rc_d;
	logic            held_q, held_d;
	logic [ID_W-1:0] owner_q, owner_d;
	logic [HW-1:0]   head_q, head_d;
	logic [CW-1:0]   count_q, count_d;

	logic [ID_W-1:0] p_id_q, p_id_d;
	logic            p_wm_q, p_wm_d;

	logic            strobe_q, strobe_d;
	logic [ID_W-1:0] tid_q, tid_d;
	logic            wm_q, wm_d;
	status_t         st_q, st_d;
	logic            last_q, last_d;

	logic               we;
	logic [HW-1:0]      waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;

	logic [SW-1:0] tail_sum;
	logic [HW-1:0] tail;
	logic [HW-1:0] head_inc;
	logic          full;
	logic          front_w;
	logic          wake_try;
	logic          wake_first;
	logic          more;
	logic          id_bad;

	rwlm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (head_d),
		.rdata (rdata)
	);

	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign tail     = (tail_sum >= DEPTH_S) ? HW'(tail_sum - DEPTH_S) : HW'(tail_sum);
	assign head_inc = (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
	assign full     = (count_q == COUNT_MAX);
	assign front_w  = rdata[ENTRY_W-1];
	assign id_bad   = ({5'd0, id_q} >= REQ_LIMIT);

	always_comb begin
		state_d    = state_q;
		rc_d       = rc_q;
		held_d     = held_q;
		owner_d    = owner_q;
		head_d     = head_q;
		count_d    = count_q;
		p_id_d     = p_id_q;
		p_wm_d     = p_wm_q;
		strobe_d   = 1'b0;
		tid_d      = tid_q;
		wm_d       = wm_q;
		st_d       = st_q;
		last_d     = last_q;
		we         = 1'b0;
		waddr      = tail;
		wdata      = {act_q[1], id_q};
		wake_try   = 1'b0;
		wake_first = 1'b0;
		more       = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				strobe_d = 1'b1;
				tid_d    = id_q;
				wm_d     = act_q[1];
				if (id_bad) begin
					st_d = ST_REL_ERR;
				end else begin
					case (act_q)
						ACT_RD_ACQ: begin
							if (held_q) begin
								if (full) begin
									st_d = ST_FULL;
								end else begin
									we      = 1'b1;
									count_d = count_q + 1'b1;
									st_d    = ST_QUEUED;
								end
							end else if (rc_q == READER_MAX) begin
								st_d = ST_FULL;
							end else begin
								rc_d = rc_q + 1'b1;
								st_d = ST_GRANTED;
							end
						end
						ACT_RD_REL: begin
							if (rc_q == '0) begin
								st_d = ST_REL_ERR;
							end else begin
								rc_d     = rc_q - 1'b1;
								st_d     = ST_RELEASED;
								wake_try = (rc_q == RC_W'(1));
							end
						end
						ACT_WR_ACQ: begin
							if (held_q || rc_q != '0) begin
								if (full) begin
									st_d = ST_FULL;
								end else begin
									we      = 1'b1;
									count_d = count_q + 1'b1;
									st_d    = ST_QUEUED;
								end
							end else begin
								held_d  = 1'b1;
								owner_d = id_q;
								st_d    = ST_GRANTED;
							end
						end
						ACT_WR_REL: begin
							if (!held_q || owner_q != id_q) begin
								st_d = ST_REL_ERR;
							end else begin
								held_d   = 1'b0;
								st_d     = ST_RELEASED;
								wake_try = 1'b1;
							end
						end
						default: begin
							st_d = ST_REL_ERR;
						end
					endcase
				end
				wake_first = wake_try && count_q != '0 && !held_d &&
					(front_w ? (rc_d == '0) : (rc_d < READER_MAX));
				last_d = !wake_first;
				if (wake_first) begin
					head_d  = head_inc;
					count_d = count_q - 1'b1;
					p_id_d  = rdata[ID_W-1:0];
					p_wm_d  = front_w;
					if (front_w) begin
						held_d  = 1'b1;
						owner_d = rdata[ID_W-1:0];
					end else begin
						rc_d = rc_d + 1'b1;
					end
					state_d = S_CHK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_CHK: begin
				more = !p_wm_q && count_q != '0 && rc_q < READER_MAX && !front_w;
				strobe_d = 1'b1;
				tid_d    = p_id_q;
				wm_d     = p_wm_q;
				st_d     = ST_WOKEN;
				last_d   = !more;
				if (more) begin
					head_d  = head_inc;
					count_d = count_q - 1'b1;
					rc_d    = rc_q + 1'b1;
					p_id_d  = rdata[ID_W-1:0];
					p_wm_d  = 1'b0;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rc_q     <= '0;
			held_q   <= 1'b0;
			owner_q  <= '0;
			head_q   <= '0;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rc_q     <= rc_d;
			held_q   <= held_d;
			owner_q  <= owner_d;
			head_q   <= head_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			act_q <= action_t'(action);
			id_q  <= requester_id;
		end
		p_id_q <= p_id_d;
		p_wm_q <= p_wm_d;
		tid_q  <= tid_d;
		wm_q   <= wm_d;
		st_q   <= st_d;
		last_q <= last_d;
	end

	assign busy       = (state_q != S_IDLE);
	assign strobe     = strobe_q;
	assign target_id  = tid_q;
	assign write_mode = wm_q;
	assign status     = st_q;
	assign last       = last_q;

	`RWLM_ASSERT_IMP(a_writer_excl, held_q, rc_q == '0, "readers counted while writer holds")
	`RWLM_ASSERT_IMP(a_count_range, 1'b1, count_q <= COUNT_MAX, "queue count past depth")
	`RWLM_ASSERT_NXT(a_burst_cont, strobe_q && !last_q, strobe_q, "gap inside a result burst")
	`RWLM_ASSERT_DLY2(a_first_result, start && !busy, strobe_q, "no result after accept")
	`RWLM_ASSERT_IMP(a_writer_wake_last, strobe_q && st_q == ST_WOKEN && wm_q, last_q,
		"woken writer not final")

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for reader_writer_lock_manager_core: directed and random lock requests,
// results predicted by a behavioural lock model and compared word by word.
// Depends on rwlm_pkg and the core RTL.
`default_nettype none

module testbench
	import rwlm_pkg::*;
;

	localparam int QDEPTH         = DEF_QUEUE_DEPTH;
	localparam int MAX_WORDS      = QDEPTH + 1;
	localparam int GEN            = 0;
	localparam int CHK            = 1;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            wm;
		status_t         st;
		logic            last;
	} lock_word_t;

	typedef struct packed {
		logic            drain;
		action_t         act;
		logic [ID_W-1:0] id;
	} lock_req_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic [1:0]      action = 2'd0;
	logic [ID_W-1:0] requester_id = '0;
	logic            busy;
	logic            strobe;
	logic [ID_W-1:0] target_id;
	logic            write_mode;
	logic [2:0]      status;
	logic            last;

	// lock model state; GEN shadows stimulus generation, CHK follows accepted words
	logic [RC_W-1:0]    rd_cnt   [2];
	logic               wr_held  [2];
	logic [ID_W-1:0]    wr_owner [2];
	logic [ENTRY_W-1:0] waitq    [2][QDEPTH];
	logic [3:0]         q_head   [2];
	logic [4:0]         q_cnt    [2];

	lock_req_t  pending_reqs[$];
	lock_word_t expected_words[$];
	logic       req_taken = 1'b0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         idle_cycles = 0;
	int         error_count = 0;

	reader_writer_lock_manager_core #(
		.QUEUE_DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.requester_id(requester_id),
		.strobe(strobe),
		.target_id(target_id),
		.write_mode(write_mode),
		.status(status),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic lock_step(input int m, input action_t act, input logic [ID_W-1:0] id,
			output lock_word_t res [MAX_WORDS], output int n);
		logic         wm;
		logic         do_wake;
		logic [ENTRY_W-1:0] e;
		int           tail;
		wm = act[1];
		do_wake = 1'b0;
		n = 1;
		res[0] = '{id, wm, ST_GRANTED, 1'b0};
		tail = (int'(q_head[m]) + int'(q_cnt[m])) % QDEPTH;
		if (int'(id) >= REQUESTERS) begin
			res[0].st = ST_REL_ERR;
		end else begin
			case (act)
				ACT_RD_ACQ: begin
					if (wr_held[m]) begin
						if (int'(q_cnt[m]) >= QDEPTH) begin
							res[0].st = ST_FULL;
						end else begin
							waitq[m][tail] = {1'b0, id};
							q_cnt[m]++;
							res[0].st = ST_QUEUED;
						end
					end else if (rd_cnt[m] >= READER_MAX) begin
						res[0].st = ST_FULL;
					end else begin
						rd_cnt[m]++;
					end
				end
				ACT_RD_REL: begin
					if (rd_cnt[m] == 0) begin
						res[0].st = ST_REL_ERR;
					end else begin
						rd_cnt[m]--;
						res[0].st = ST_RELEASED;
						do_wake = (rd_cnt[m] == 0);
					end
				end
				ACT_WR_ACQ: begin
					if (wr_held[m] || rd_cnt[m] != 0) begin
						if (int'(q_cnt[m]) >= QDEPTH) begin
							res[0].st = ST_FULL;
						end else begin
							waitq[m][tail] = {1'b1, id};
							q_cnt[m]++;
							res[0].st = ST_QUEUED;
						end
					end else begin
						wr_held[m] = 1'b1;
						wr_owner[m] = id;
					end
				end
				default: begin
					if (!wr_held[m] || wr_owner[m] != id) begin
						res[0].st = ST_REL_ERR;
					end else begin
						wr_held[m] = 1'b0;
						res[0].st = ST_RELEASED;
						do_wake = 1'b1;
					end
				end
			endcase
		end
		if (do_wake && !wr_held[m] && q_cnt[m] != 0) begin
			e = waitq[m][q_head[m]];
			if (e[ID_W]) begin
				if (rd_cnt[m] == 0) begin
					q_head[m] = 4'((int'(q_head[m]) + 1) % QDEPTH);
					q_cnt[m]--;
					wr_held[m] = 1'b1;
					wr_owner[m] = e[ID_W-1:0];
					res[n] = '{e[ID_W-1:0], 1'b1, ST_WOKEN, 1'b0};
					n++;
				end
			end else begin
				while (q_cnt[m] != 0 && rd_cnt[m] < READER_MAX
						&& !waitq[m][q_head[m]][ID_W]) begin
					e = waitq[m][q_head[m]];
					q_head[m] = 4'((int'(q_head[m]) + 1) % QDEPTH);
					q_cnt[m]--;
					rd_cnt[m]++;
					res[n] = '{e[ID_W-1:0], 1'b0, ST_WOKEN, 1'b0};
					n++;
				end
			end
		end
		res[n-1].last = 1'b1;
	endtask

	task automatic push_req(input action_t act, input logic [ID_W-1:0] id);
		lock_word_t scratch [MAX_WORDS];
		int         cnt;
		lock_step(GEN, act, id, scratch, cnt);
		pending_reqs.push_back('{1'b0, act, id});
	endtask

	task automatic push_drain();
		pending_reqs.push_back('{1'b1, ACT_RD_ACQ, '0});
	endtask

	task automatic push_random_req();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			push_req(action_t'($urandom_range(3)), ID_W'($urandom_range(63)));
		else if (wr_held[GEN] && $urandom_range(2) == 0)
			push_req(ACT_WR_REL, wr_owner[GEN]);
		else if (rd_cnt[GEN] != 0 && $urandom_range(1) == 0)
			push_req(ACT_RD_REL, ID_W'($urandom_range(63)));
		else if ($urandom_range(1) == 0)
			push_req(ACT_RD_ACQ, ID_W'($urandom_range(63)));
		else
			push_req(ACT_WR_ACQ, ID_W'($urandom_range(63)));
	endtask

	// driver: one request word held on the ports until accepted
	always @(negedge clk) begin : drive
		logic go;
		go = 1'b0;
		if (arst_n) begin
			if (start && req_taken) begin
				void'(pending_reqs.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_reqs.size() != 0) begin
				if (pending_reqs[0].drain) begin
					if (expected_words.size() == 0 && !busy)
						void'(pending_reqs.pop_front());
				end else begin
					go = 1'b1;
					if (burst_left == 0)
						burst_left = ($urandom_range(7) == 0) ? 60 : $urandom_range(1, 12);
					action <= pending_reqs[0].act;
					requester_id <= pending_reqs[0].id;
				end
			end
		end
		start <= go;
	end

	// monitor: predict on accept, check each strobed word against the oldest expectation
	always @(posedge clk) begin : monitor
		lock_word_t words [MAX_WORDS];
		lock_word_t got;
		lock_word_t want;
		int         nw;
		if (arst_n) begin
			req_taken <= start && !busy;
			if (start && !busy) begin
				lock_step(CHK, action_t'(action), requester_id, words, nw);
				for (int i = 0; i < nw; i++)
					expected_words.push_back(words[i]);
			end
			if (strobe) begin
				got = '{target_id, write_mode, status_t'(status), last};
				if (expected_words.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected word: id=%0d wm=%0d status=%0d last=%0d",
							got.id, got.wm, got.st, got.last);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display({"mismatch: expected id=%0d wm=%0d status=%0d last=%0d,",
								" got id=%0d wm=%0d status=%0d last=%0d"},
								want.id, want.wm, want.st, want.last,
								got.id, got.wm, got.st, got.last);
					end
				end
			end
			if ((start && !busy) || strobe)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[reader_writer_lock_manager_core] ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [ID_W-1:0] w;
		for (int m = 0; m < 2; m++) begin
			rd_cnt[m] = '0;
			wr_held[m] = 1'b0;
			wr_owner[m] = '0;
			q_head[m] = '0;
			q_cnt[m] = '0;
			for (int i = 0; i < QDEPTH; i++)
				waitq[m][i] = '0;
		end

		// directed: underflow, non-holder releases, waking order, repeated acquire
		push_req(ACT_RD_REL, 6'd0);
		push_req(ACT_WR_REL, 6'd63);
		push_req(ACT_RD_ACQ, 6'd0);
		push_req(ACT_RD_ACQ, 6'd63);
		push_req(ACT_WR_ACQ, 6'd5);
		push_req(ACT_RD_ACQ, 6'd42);
		push_req(ACT_WR_REL, 6'd5);
		push_req(ACT_RD_REL, 6'd0);
		push_req(ACT_RD_REL, 6'd63);
		push_req(ACT_RD_REL, 6'd42);
		push_req(ACT_WR_REL, 6'd7);
		push_req(ACT_RD_ACQ, 6'd10);
		push_req(ACT_RD_ACQ, 6'd11);
		push_req(ACT_WR_ACQ, 6'd12);
		push_req(ACT_RD_ACQ, 6'd13);
		push_req(ACT_WR_ACQ, 6'd5);
		push_req(ACT_WR_REL, 6'd5);
		push_req(ACT_RD_REL, 6'd10);
		push_req(ACT_RD_REL, 6'd11);
		push_req(ACT_WR_REL, 6'd12);
		push_req(ACT_RD_REL, 6'd13);
		push_req(ACT_WR_REL, 6'd5);
		push_drain();

		// full wait queue, then one release waking every queued reader
		w = ID_W'($urandom_range(63));
		push_req(ACT_WR_ACQ, w);
		for (int i = 0; i <= QDEPTH; i++)
			push_req(ACT_RD_ACQ, ID_W'($urandom_range(63)));
		push_req(ACT_WR_ACQ, ID_W'($urandom_range(63)));
		push_req(ACT_WR_REL, w);
		while (rd_cnt[GEN] != 0)
			push_req(ACT_RD_REL, ID_W'($urandom_range(63)));
		push_drain();

		// reader count up to its ceiling and beyond
		while (wr_held[GEN])
			push_req(ACT_WR_REL, wr_owner[GEN]);
		while (rd_cnt[GEN] < READER_MAX)
			push_req(ACT_RD_ACQ, ID_W'($urandom_range(63)));
		push_req(ACT_RD_ACQ, ID_W'($urandom_range(63)));
		push_req(ACT_RD_ACQ, ID_W'($urandom_range(63)));
		while (rd_cnt[GEN] > 4)
			push_req(ACT_RD_REL, ID_W'($urandom_range(63)));
		push_drain();

		for (int i = 0; i < 150; i++)
			push_random_req();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || expected_words.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (error_count == 0 && expected_words.size() == 0)
			$display("[reader_writer_lock_manager_core] OK");
		else
			$display("[reader_writer_lock_manager_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
